// ----- rtl/cholesky_factorization_defines.svh -----
// assertion macros shared by the cholesky block
// no dependencies
`ifndef CHOLESKY_FACTORIZATION_DEFINES_SVH
`define CHOLESKY_FACTORIZATION_DEFINES_SVH
`define CHOL_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define CHOL_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ----- rtl/chol_pkg.sv -----
// package for the cholesky factorisation block: constants, types, helpers
// no dependencies
package chol_pkg;
    localparam int MAX_ORDER = 8;
    localparam int FRAC_BITS = 16;
    localparam int DEPTH = MAX_ORDER * MAX_ORDER;
    localparam int IDX_W = $clog2(MAX_ORDER);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int ORD_W = $clog2(MAX_ORDER + 1);
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_ASYM = 2'd1;
    localparam logic [1:0] ST_NOTPD = 2'd2;
    localparam logic [0:0] REG_MATRIX_SIZE = 1'b0;

    typedef struct packed {
        logic signed [31:0] val;
        logic [ADDR_W-1:0]  addr;
        logic               last;
    } elem_t;

    typedef struct packed {
        logic signed [31:0] lower_value;
        logic [2:0]         row;
        logic [2:0]         col;
        logic [1:0]         status;
        logic               last_result;
    } result_t;

    typedef enum logic [4:0] {
        S_IDLE, S_SYM_RD, S_SYM_CMP, S_ENTRY, S_MAC_RD, S_MAC_MUL, S_MAC_ACC,
        S_ARD, S_AWAIT, S_DIAG, S_SQRT, S_DIV_SETUP, S_DIV, S_DIV_END,
        S_FAIL, S_OUT_RD, S_OUT_WAIT, S_OUT
    } back_state_t;

    function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
        addr_of = ADDR_W'(r) * ADDR_W'(MAX_ORDER) + ADDR_W'(c);
    endfunction

    function automatic logic [ORD_W-1:0] order_of(input logic [3:0] sz);
        logic [ORD_W:0] n;
        n = (ORD_W+1)'(sz);
        if (n == '0) n = (ORD_W+1)'(1);
        if (n > (ORD_W+1)'(MAX_ORDER)) n = (ORD_W+1)'(MAX_ORDER);
        order_of = n[ORD_W-1:0];
    endfunction
endpackage

// ----- rtl/chol_if.sv -----
// valid/ready channel interface for the cholesky block
// no dependencies
interface chol_in_if;
    logic valid;
    logic ready;
    logic signed [31:0] element_value;
    modport source (output valid, output element_value, input ready);
    modport sink (input valid, input element_value, output ready);
endinterface

interface chol_out_if;
    logic valid;
    logic ready;
    logic signed [31:0] lower_value;
    logic [2:0] row;
    logic [2:0] col;
    logic [1:0] status;
    logic last_result;
    modport source (output valid, output lower_value, output row, output col,
                    output status, output last_result, input ready);
    modport sink (input valid, input lower_value, input row, input col,
                  input status, input last_result, output ready);
endinterface

// ----- rtl/chol_front.sv -----
// front part: accepts elements, tags them with store address and matrix end
// uses chol_pkg
module chol_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [31:0]         element_value,
    input  logic [chol_pkg::ORD_W-1:0] order,
    input  logic                       cfg_wr,
    output logic                       q_push,
    output chol_pkg::elem_t            q_data,
    input  logic                       q_full
);
    logic [chol_pkg::IDX_W-1:0] row_reg, row_next;
    logic [chol_pkg::IDX_W-1:0] col_reg, col_next;
    logic                       col_end;
    logic                       row_end;

    assign in_ready = !q_full;
    assign q_push = in_valid && in_ready;
    assign col_end = ({1'b0, col_reg} == chol_pkg::ORD_W'(order - 1'b1));
    assign row_end = ({1'b0, row_reg} == chol_pkg::ORD_W'(order - 1'b1));
    assign q_data.val = element_value;
    assign q_data.addr = chol_pkg::addr_of(row_reg, col_reg);
    assign q_data.last = col_end && row_end;

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (cfg_wr)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (q_push)
        begin
            if (col_end)
            begin
                col_next = '0;
                row_next = row_end ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end
endmodule

// ----- rtl/chol_queue.sv -----
// short element queue between front and back parts
// uses chol_pkg
module chol_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  chol_pkg::elem_t push_data,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output chol_pkg::elem_t pop_data
);
    chol_pkg::elem_t                 mem [chol_pkg::QDEPTH];
    logic [chol_pkg::QPTR_W-1:0]     wp_reg, rp_reg;
    logic [chol_pkg::QPTR_W:0]       cnt_reg;

    assign full = (cnt_reg == (chol_pkg::QPTR_W+1)'(chol_pkg::QDEPTH));
    assign not_empty = (cnt_reg != '0);
    assign pop_data = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (chol_pkg::QPTR_W+1)'(push)
                       - (chol_pkg::QPTR_W+1)'(pop);
        end
    end
endmodule

// ----- rtl/chol_back.sv -----
// back part: stores the matrix, checks symmetry, factors, emits results
// uses chol_pkg
module chol_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    input  chol_pkg::elem_t            q_data,
    output logic                       q_pop,
    input  logic [chol_pkg::ORD_W-1:0] order,
    output logic                       out_valid,
    input  logic                       out_ready,
    output chol_pkg::result_t          out_data,
    output logic                       busy
);
    logic signed [31:0] a_mem [chol_pkg::DEPTH];
    logic signed [31:0] l_mem [chol_pkg::DEPTH];

    chol_pkg::back_state_t state_reg, state_next;
    logic [chol_pkg::IDX_W-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic signed [31:0] a_rd_reg, b_rd_reg, l1_reg, l2_reg;
    logic signed [63:0] prod_reg, prod_next;
    logic signed [63:0] sum_reg, sum_next;
    logic [63:0] x_reg, x_next, res_reg, res_next, bit_reg, bit_next;
    logic [63:0] rem_reg, rem_next, den_reg, den_next, quo_reg, quo_next;
    logic neg_reg, neg_next;
    logic [6:0] cnt_reg, cnt_next;
    logic oval_reg, oval_next;
    chol_pkg::result_t od_reg, od_next;

    logic [chol_pkg::ADDR_W-1:0] ra_a, ra_b, rl_a, rl_b, wl_addr;
    logic        wl_en;
    logic signed [31:0] wl_data;
    logic [chol_pkg::IDX_W-1:0] nlast;
    logic signed [63:0] diff, satd;
    logic [63:0] trial, rem_sh;

    assign nlast = chol_pkg::IDX_W'(order - 1'b1);
    assign out_valid = oval_reg;
    assign out_data = od_reg;
    assign busy = (state_reg != chol_pkg::S_IDLE) || q_valid;
    assign q_pop = (state_reg == chol_pkg::S_IDLE) && q_valid;

    always_ff @(posedge clk)
    begin
        if (q_pop)
            a_mem[q_data.addr] <= q_data.val;
        a_rd_reg <= a_mem[ra_a];
        b_rd_reg <= a_mem[ra_b];
        if (wl_en)
            l_mem[wl_addr] <= wl_data;
        l1_reg <= l_mem[rl_a];
        l2_reg <= l_mem[rl_b];
    end

    assign diff = 64'(a_rd_reg) - sum_reg;
    assign satd = (diff > 64'sd2147483647) ? 64'sd2147483647 :
                  (diff < -64'sd2147483648) ? -64'sd2147483648 : diff;
    assign trial = res_reg + bit_reg;
    assign rem_sh = {rem_reg[62:0], quo_reg[63]};

    always_comb
    begin
        state_next = state_reg;
        i_next = i_reg;
        j_next = j_reg;
        k_next = k_reg;
        prod_next = prod_reg;
        sum_next = sum_reg;
        x_next = x_reg;
        res_next = res_reg;
        bit_next = bit_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        quo_next = quo_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        oval_next = oval_reg;
        od_next = od_reg;
        ra_a = chol_pkg::addr_of(i_reg, j_reg);
        ra_b = chol_pkg::addr_of(j_reg, i_reg);
        rl_a = chol_pkg::addr_of(i_reg, k_reg);
        rl_b = chol_pkg::addr_of(j_reg, k_reg);
        wl_en = 1'b0;
        wl_addr = chol_pkg::addr_of(i_reg, j_reg);
        wl_data = '0;
        if (oval_reg && out_ready)
            oval_next = 1'b0;
        unique case (state_reg)
            chol_pkg::S_IDLE:
            begin
                if (q_pop && q_data.last)
                begin
                    i_next = '0;
                    j_next = '0;
                    state_next = chol_pkg::S_SYM_RD;
                end
            end
            chol_pkg::S_SYM_RD:
                state_next = chol_pkg::S_SYM_CMP;
            chol_pkg::S_SYM_CMP:
            begin
                if (a_rd_reg != b_rd_reg)
                    state_next = chol_pkg::S_FAIL;
                else if (j_reg == nlast)
                begin
                    if (i_reg == nlast)
                    begin
                        i_next = '0;
                        j_next = '0;
                        state_next = chol_pkg::S_ENTRY;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                        j_next = i_reg + 1'b1;
                        state_next = chol_pkg::S_SYM_RD;
                    end
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                    state_next = chol_pkg::S_SYM_RD;
                end
            end
            chol_pkg::S_ENTRY:
            begin
                sum_next = '0;
                k_next = '0;
                state_next = (j_reg == '0) ? chol_pkg::S_ARD : chol_pkg::S_MAC_RD;
            end
            chol_pkg::S_MAC_RD:
                state_next = chol_pkg::S_MAC_MUL;
            chol_pkg::S_MAC_MUL:
            begin
                prod_next = 64'(l1_reg) * 64'(l2_reg);
                state_next = chol_pkg::S_MAC_ACC;
            end
            chol_pkg::S_MAC_ACC:
            begin
                if (prod_reg < 0)
                    sum_next = sum_reg - ((-prod_reg) >>> chol_pkg::FRAC_BITS);
                else
                    sum_next = sum_reg + (prod_reg >>> chol_pkg::FRAC_BITS);
                if (k_reg + 1'b1 == j_reg)
                    state_next = chol_pkg::S_ARD;
                else
                begin
                    k_next = k_reg + 1'b1;
                    state_next = chol_pkg::S_MAC_RD;
                end
            end
            chol_pkg::S_ARD:
            begin
                k_next = j_reg;
                state_next = chol_pkg::S_AWAIT;
            end
            chol_pkg::S_AWAIT:
            begin
                rl_a = chol_pkg::addr_of(j_reg, j_reg);
                state_next = chol_pkg::S_DIAG;
            end
            chol_pkg::S_DIAG:
            begin
                rl_a = chol_pkg::addr_of(j_reg, j_reg);
                if (i_reg == j_reg)
                begin
                    if (diff <= 0)
                        state_next = chol_pkg::S_FAIL;
                    else
                    begin
                        x_next = 64'(diff) << chol_pkg::FRAC_BITS;
                        res_next = '0;
                        bit_next = 64'd1 << 62;
                        state_next = chol_pkg::S_SQRT;
                    end
                end
                else
                    state_next = chol_pkg::S_DIV_SETUP;
            end
            chol_pkg::S_SQRT:
            begin
                if (bit_reg == '0)
                begin
                    wl_en = 1'b1;
                    wl_data = (res_reg > 64'd2147483647) ? 32'sh7fffffff : 32'(res_reg);
                    state_next = chol_pkg::S_DIV_END;
                end
                else
                begin
                    if (x_reg >= trial)
                    begin
                        x_next = x_reg - trial;
                        res_next = (res_reg >> 1) + bit_reg;
                    end
                    else
                        res_next = res_reg >> 1;
                    bit_next = bit_reg >> 2;
                end
            end
            chol_pkg::S_DIV_SETUP:
            begin
                neg_next = satd[63];
                quo_next = (satd[63] ? 64'(-satd) : 64'(satd)) << chol_pkg::FRAC_BITS;
                den_next = 64'(l1_reg);
                rem_next = '0;
                cnt_next = 7'd64;
                if (l1_reg <= 0)
                begin
                    wl_en = 1'b1;
                    state_next = chol_pkg::S_DIV_END;
                end
                else
                    state_next = chol_pkg::S_DIV;
            end
            chol_pkg::S_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    wl_en = 1'b1;
                    if (neg_reg)
                        wl_data = (quo_reg > 64'd2147483648) ? 32'sh80000000 : 32'(-quo_reg);
                    else
                        wl_data = (quo_reg > 64'd2147483647) ? 32'sh7fffffff : 32'(quo_reg);
                    state_next = chol_pkg::S_DIV_END;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                    if (rem_sh >= den_reg)
                    begin
                        rem_next = rem_sh - den_reg;
                        quo_next = {quo_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rem_sh;
                        quo_next = {quo_reg[62:0], 1'b0};
                    end
                end
            end
            chol_pkg::S_DIV_END:
            begin
                if (j_reg == i_reg)
                begin
                    if (i_reg == nlast)
                    begin
                        i_next = '0;
                        j_next = '0;
                        state_next = chol_pkg::S_OUT_RD;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                        j_next = '0;
                        state_next = chol_pkg::S_ENTRY;
                    end
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                    state_next = chol_pkg::S_ENTRY;
                end
            end
            chol_pkg::S_FAIL:
            begin
                // a failed diagonal has row equal to column, a symmetry mismatch never does
                if (!oval_reg || out_ready)
                begin
                    oval_next = 1'b1;
                    od_next = '{32'sd0, 3'(i_reg), 3'(j_reg),
                                (i_reg == j_reg) ? chol_pkg::ST_NOTPD : chol_pkg::ST_ASYM,
                                1'b1};
                    state_next = chol_pkg::S_IDLE;
                end
            end
            chol_pkg::S_OUT_RD:
            begin
                rl_a = chol_pkg::addr_of(i_reg, j_reg);
                state_next = chol_pkg::S_OUT_WAIT;
            end
            chol_pkg::S_OUT_WAIT:
            begin
                rl_a = chol_pkg::addr_of(i_reg, j_reg);
                state_next = chol_pkg::S_OUT;
            end
            chol_pkg::S_OUT:
            begin
                rl_a = chol_pkg::addr_of(i_reg, j_reg);
                if (!oval_reg || out_ready)
                begin
                    oval_next = 1'b1;
                    od_next = '{(j_reg <= i_reg) ? l1_reg : 32'sd0, 3'(i_reg), 3'(j_reg),
                                chol_pkg::ST_OK, (i_reg == nlast) && (j_reg == nlast)};
                    if (j_reg == nlast)
                    begin
                        j_next = '0;
                        if (i_reg == nlast)
                            state_next = chol_pkg::S_IDLE;
                        else
                        begin
                            i_next = i_reg + 1'b1;
                            state_next = chol_pkg::S_OUT_RD;
                        end
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                        state_next = chol_pkg::S_OUT_RD;
                    end
                end
            end
            default:
                state_next = chol_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= chol_pkg::S_IDLE;
            oval_reg <= 1'b0;
            i_reg <= '0;
            j_reg <= '0;
            k_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            oval_reg <= oval_next;
            i_reg <= i_next;
            j_reg <= j_next;
            k_reg <= k_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        sum_reg <= sum_next;
        x_reg <= x_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
        neg_reg <= neg_next;
        od_reg <= od_next;
    end
endmodule

// ----- rtl/cholesky_factorization.sv -----
// channel    dir  payload                                  transaction when
// in_ch      in   element_value                            valid && ready
// out_ch     out  lower_value, row, col, status, last_result valid && ready
// apb        in   matrix_size at address 0                 psel&penable&pwrite
// elements are taken at one per cycle, while the queue is not full, into a four-deep queue and stored
// after the last element the back part checks symmetry, then factors with one shared
// multiplier, a 32-step square root per diagonal entry and a 64-step divider per other entry
// results leave from a registered output stage, each read through S_OUT_RD and S_OUT_WAIT first
// reset clears all control; no clearing pass is needed for the stores
// top level of the cholesky factorisation block; uses chol_pkg, chol_if,
// chol_front, chol_queue, chol_back and the assertion macro header
`include "cholesky_factorization_defines.svh"
module cholesky_factorization (
    input  logic        clk,
    input  logic        rst_n,
    chol_in_if.sink     in_ch,
    chol_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [3:0]                 size_reg;
    logic [chol_pkg::ORD_W-1:0] order;
    logic                       cfg_wr;
    logic                       q_push, q_full, q_pop, q_ne, busy;
    chol_pkg::elem_t            q_in, q_out;
    chol_pkg::result_t          res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == chol_pkg::REG_MATRIX_SIZE)
                    && (paddr[1:0] == 2'b00);
    assign prdata = (paddr[2] == chol_pkg::REG_MATRIX_SIZE) ? {28'd0, size_reg} : 32'd0;
    assign order = chol_pkg::order_of(size_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_reg <= 4'd8;
        else if (cfg_wr)
            size_reg <= pwdata[3:0];
    end

    chol_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .element_value(in_ch.element_value), .order(order), .cfg_wr(cfg_wr),
        .q_push(q_push), .q_data(q_in), .q_full(q_full)
    );

    chol_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_in), .full(q_full),
        .pop(q_pop), .not_empty(q_ne), .pop_data(q_out)
    );

    chol_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_ne), .q_data(q_out), .q_pop(q_pop),
        .order(order), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .out_data(res), .busy(busy)
    );

    assign out_ch.lower_value = res.lower_value;
    assign out_ch.row = res.row;
    assign out_ch.col = res.col;
    assign out_ch.status = res.status;
    assign out_ch.last_result = res.last_result;

    `CHOL_ASSERT_IMP(a_no_push_full, clk, rst_n, q_full, !q_push)
    `CHOL_ASSERT_IMP(a_fail_last, clk, rst_n, out_ch.valid && (res.status != chol_pkg::ST_OK),
                     res.last_result)
    `CHOL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready,
                      out_ch.valid && $stable(res))
    `CHOL_ASSERT_IMP(a_cfg_idle, clk, rst_n, cfg_wr, !busy)
endmodule

// ----- dv/testbench.sv -----
// self-checking testbench for cholesky_factorization: loads matrices, predicts L
// depends on chol_pkg, chol_if and the rtl of the block
`timescale 1ns / 1ps
module testbench;
    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    chol_in_if  in_ch ();
    chol_out_if out_ch ();

    cholesky_factorization u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    localparam longint ONE = longint'(1) << chol_pkg::FRAC_BITS;

    logic [31:0]       element_queue[$];
    chol_pkg::result_t factor_expected[$];
    longint      a_store[chol_pkg::DEPTH];
    longint      l_store[chol_pkg::DEPTH];
    int unsigned size_reg;
    int unsigned loaded;
    int          errors;
    int          send_gap;
    int          recv_gap;
    bit          burst;
    int          matrices;
    int          results_seen;
    longint      a_gen[8][8];

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic bit [63:0] int_sqrt(input bit [63:0] x);
        bit [63:0] res;
        bit [63:0] b;
        res = '0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic void push_result(input longint v, input int r, input int c,
                                        input logic [1:0] st, input bit lst);
        chol_pkg::result_t e;
        e.lower_value = v[31:0];
        e.row = r[2:0];
        e.col = c[2:0];
        e.status = st;
        e.last_result = lst;
        factor_expected.push_back(e);
    endfunction

    function automatic void factorise(input int n);
        longint    sum;
        longint    rad;
        longint    num;
        longint    d;
        bit [63:0] sq;
        for (int i = 0; i < n; i++)
            for (int j = i + 1; j < n; j++)
                if (a_store[i*chol_pkg::MAX_ORDER+j] != a_store[j*chol_pkg::MAX_ORDER+i])
                begin
                    push_result(0, i, j, chol_pkg::ST_ASYM, 1'b1);
                    return;
                end
        for (int i = 0; i < n; i++)
            for (int j = 0; j <= i; j++)
            begin
                sum = 0;
                for (int k = 0; k < j; k++)
                    sum += (l_store[i*chol_pkg::MAX_ORDER+k] *
                            l_store[j*chol_pkg::MAX_ORDER+k]) / ONE;
                if (i == j)
                begin
                    rad = a_store[i*chol_pkg::MAX_ORDER+i] - sum;
                    if (rad <= 0)
                    begin
                        push_result(0, i, i, chol_pkg::ST_NOTPD, 1'b1);
                        return;
                    end
                    sq = int_sqrt(64'(rad) * 64'(ONE));
                    l_store[i*chol_pkg::MAX_ORDER+i] = (sq > 64'd2147483647) ? 64'sd2147483647
                                                                              : longint'(sq);
                end
                else
                begin
                    num = sat32(a_store[i*chol_pkg::MAX_ORDER+j] - sum);
                    d = l_store[j*chol_pkg::MAX_ORDER+j];
                    l_store[i*chol_pkg::MAX_ORDER+j] = sat32((d > 0) ? (num * ONE) / d : 0);
                end
            end
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                push_result((j <= i) ? l_store[i*chol_pkg::MAX_ORDER+j] : 0, i, j,
                            chol_pkg::ST_OK, (i == n - 1) && (j == n - 1));
    endfunction

    function automatic void load_element(input logic [31:0] v);
        int n;
        n = (size_reg == 0) ? 1 : ((size_reg > chol_pkg::MAX_ORDER) ? chol_pkg::MAX_ORDER
                                                                      : size_reg);
        if (loaded >= n * n) loaded = 0;
        a_store[(loaded / n) * chol_pkg::MAX_ORDER + (loaded % n)] = longint'($signed(v));
        loaded++;
        if (loaded == n * n)
        begin
            loaded = 0;
            matrices++;
            factorise(n);
        end
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.element_value <= '0;
            send_gap <= 0;
        end
        else if (in_ch.valid && in_ch.ready)
        begin
            load_element(in_ch.element_value);
            if (burst && element_queue.size() > 0)
                in_ch.element_value <= element_queue.pop_front();
            else
            begin
                in_ch.valid <= 1'b0;
                send_gap <= burst ? 0 : $urandom_range(0, 17);
            end
        end
        else if (!in_ch.valid)
        begin
            if (send_gap > 0)
                send_gap <= send_gap - 1;
            else if (element_queue.size() > 0)
            begin
                in_ch.valid <= 1'b1;
                in_ch.element_value <= element_queue.pop_front();
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                results_seen++;
                if (factor_expected.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected transaction: value %0d row %0d col %0d st %0d",
                             $time, out_ch.lower_value, out_ch.row, out_ch.col,
                             out_ch.status);
                end
                else if (factor_expected[0] != {out_ch.lower_value, out_ch.row, out_ch.col,
                                                out_ch.status, out_ch.last_result})
                begin
                    errors++;
                    $display("%0t mismatch: expected val %0d r %0d c %0d st %0d last %0d, got val %0d r %0d c %0d st %0d last %0d",
                             $time, factor_expected[0].lower_value, factor_expected[0].row,
                             factor_expected[0].col, factor_expected[0].status,
                             factor_expected[0].last_result, out_ch.lower_value,
                             out_ch.row, out_ch.col, out_ch.status, out_ch.last_result);
                    void'(factor_expected.pop_front());
                end
                else
                    void'(factor_expected.pop_front());
                if (!burst)
                begin
                    recv_gap <= $urandom_range(0, 17);
                    out_ch.ready <= 1'b0;
                end
            end
            else if (!out_ch.ready)
            begin
                if (recv_gap > 0)
                    recv_gap <= recv_gap - 1;
                else
                    out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic wait_idle();
        while (element_queue.size() > 0 || in_ch.valid || factor_expected.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (addr == 3'(chol_pkg::REG_MATRIX_SIZE) * 3'd4)
        begin
            size_reg = data[3:0];
            loaded = 0;
        end
    endtask

    // kind 0 positive definite, 1 asymmetric when n > 1, 2 not positive definite, 3 noise
    task automatic queue_matrix(input int n, input int kind);
        int     span;
        longint row_abs;
        int     p;
        int     q;
        span = ($urandom_range(0, 3) == 0) ? (1 << 24) : (1 << 18);
        for (int i = 0; i < n; i++)
            for (int j = 0; j < i; j++)
            begin
                a_gen[i][j] = longint'($urandom_range(0, 2 * span)) - span;
                a_gen[j][i] = a_gen[i][j];
            end
        for (int i = 0; i < n; i++)
        begin
            row_abs = 0;
            for (int j = 0; j < n; j++)
                if (j != i)
                    row_abs += (a_gen[i][j] < 0) ? -a_gen[i][j] : a_gen[i][j];
            a_gen[i][i] = row_abs + $urandom_range(1, 1 << 18);
        end
        p = $urandom_range(0, n - 1);
        if (kind == 1 && n > 1)
        begin
            q = $urandom_range(0, n - 1);
            if (q == p) q = (p + 1) % n;
            a_gen[p][q] = a_gen[p][q] + $urandom_range(1, 5);
        end
        else if (kind == 2)
            a_gen[p][p] = -longint'($urandom_range(0, 1 << 20));
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                element_queue.push_back((kind == 3) ? $urandom() : a_gen[i][j][31:0]);
    endtask

    initial
    begin
        int n;
        int kind;
        int count;
        errors = 0;
        matrices = 0;
        results_seen = 0;
        burst = 1'b0;
        loaded = 0;
        size_reg = 8;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // size after reset
        queue_matrix(8, 0);
        wait_idle();
        // size zero acts as one, extremes of the element
        apb_write(3'd0, 32'd0);
        element_queue.push_back(32'h7fffffff);
        element_queue.push_back(32'h80000000);
        element_queue.push_back(32'h00000000);
        element_queue.push_back(32'h00000001);
        wait_idle();
        // partial load is dropped by a size write, ignored address
        apb_write(3'd0, 32'd3);
        repeat (4) element_queue.push_back($urandom());
        wait_idle();
        apb_write(3'd4, 32'd5);
        apb_write(3'd0, 32'd2);
        queue_matrix(2, 1);
        queue_matrix(2, 2);
        queue_matrix(2, 0);
        element_queue.push_back(32'h00000001);
        element_queue.push_back(32'h7fffffff);
        element_queue.push_back(32'h7fffffff);
        element_queue.push_back(32'h7fffffff);
        wait_idle();

        for (int phase = 0; phase < 11; phase++)
        begin
            n = (phase == 10) ? 8 : $urandom_range(1, 5);
            apb_write(3'd0, (n == 8) ? 32'd15 : 32'(n));
            burst = ($urandom_range(0, 3) == 0);
            count = (n == 8) ? 1 : $urandom_range(1, 2);
            for (int m = 0; m < count; m++)
            begin
                kind = $urandom_range(0, 9);
                queue_matrix(n, (kind < 6) ? 0 : (kind < 7) ? 1 : (kind < 9) ? 2 : 3);
            end
            wait_idle();
        end
        burst = 1'b0;
        wait_idle();
        repeat (200) @(posedge clk);
        $display("factored %0d matrices of orders 1 to 8, %0d result transactions checked",
                 matrices, results_seen);
        if (errors == 0 && factor_expected.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #40ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule

// ----- cholesky_factorization.f -----
+incdir+rtl
rtl/chol_pkg.sv
rtl/chol_if.sv
rtl/chol_front.sv
rtl/chol_queue.sv
rtl/chol_back.sv
rtl/cholesky_factorization.sv
dv/testbench.sv
